[rtl/kal_pkg.sv]
package kal_pkg;

    localparam int CfgIdxW = 3;

    typedef enum logic [1:0] {
        OP_FRAME_START = 2'd0,
        OP_EVENT       = 2'd1,
        OP_FRAME_END   = 2'd2,
        OP_LOAD        = 2'd3
    } t_op;

    localparam logic [1:0] KIND_KEY    = 2'd0;
    localparam logic [1:0] KIND_SWITCH = 2'd1;

    localparam logic [9:0] KEY_MENU_A = 10'd314;
    localparam logic [9:0] KEY_MENU_B = 10'd315;
    localparam logic [9:0] KEY_MENU_C = 10'd316;
    localparam logic [9:0] KEY_PLUS   = 10'd115;
    localparam logic [9:0] KEY_MINUS  = 10'd114;
    localparam logic [9:0] SW_MUTE    = 10'd1;
    localparam logic [9:0] SW_JACK    = 10'd2;

    localparam logic [7:0] KEY_VAL_MAX = 8'd2;

    localparam logic [CfgIdxW-1:0] CFG_VOLUME_TOP     = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_BRIGHT_TOP     = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_REPEAT_DELAY   = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_REPEAT_INTERVAL = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_SLEEP_GAP      = 3'd4;

    localparam logic [7:0]  RST_VOLUME_TOP      = 8'd20;
    localparam logic [7:0]  RST_BRIGHT_TOP      = 8'd10;
    localparam logic [15:0] RST_REPEAT_DELAY    = 16'd300;
    localparam logic [15:0] RST_REPEAT_INTERVAL = 16'd100;
    localparam logic [15:0] RST_SLEEP_GAP       = 16'd1000;

    typedef struct packed {
        logic [7:0]  volume_top;
        logic [7:0]  brightness_top;
        logic [15:0] repeat_delay_ms;
        logic [15:0] repeat_interval_ms;
        logic [15:0] sleep_gap_ms;
    } t_cfg;

    typedef struct packed {
        t_op         operation;
        logic [1:0]  event_kind;
        logic [9:0]  event_code;
        logic [7:0]  event_value;
        logic [31:0] time_ms;
        logic [7:0]  volume_load;
        logic [7:0]  brightness_load;
    } t_item;

    typedef struct packed {
        logic [7:0] volume_level;
        logic [7:0] brightness_level;
        logic [7:0] mute_state;
        logic [7:0] jack_state;
        logic       volume_changed;
        logic       brightness_changed;
        logic       switch_written;
    } t_result;

endpackage

[rtl/kal_cfg_regs.sv]
module kal_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [kal_pkg::CfgIdxW-1:0] i_cfg_addr,
    input  logic [15:0]                 i_cfg_wdata,
    output kal_pkg::t_cfg               o_cfg
);

    kal_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.volume_top         <= kal_pkg::RST_VOLUME_TOP;
            r_cfg.brightness_top     <= kal_pkg::RST_BRIGHT_TOP;
            r_cfg.repeat_delay_ms    <= kal_pkg::RST_REPEAT_DELAY;
            r_cfg.repeat_interval_ms <= kal_pkg::RST_REPEAT_INTERVAL;
            r_cfg.sleep_gap_ms       <= kal_pkg::RST_SLEEP_GAP;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                kal_pkg::CFG_VOLUME_TOP:      r_cfg.volume_top         <= i_cfg_wdata[7:0];
                kal_pkg::CFG_BRIGHT_TOP:      r_cfg.brightness_top     <= i_cfg_wdata[7:0];
                kal_pkg::CFG_REPEAT_DELAY:    r_cfg.repeat_delay_ms    <= i_cfg_wdata;
                kal_pkg::CFG_REPEAT_INTERVAL: r_cfg.repeat_interval_ms <= i_cfg_wdata;
                kal_pkg::CFG_SLEEP_GAP:       r_cfg.sleep_gap_ms       <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/kal_core.sv]
module kal_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  kal_pkg::t_item  i_item,
    input  kal_pkg::t_cfg   i_cfg,
    output kal_pkg::t_result o_res
);

    logic [31:0] r_frame_now, r_last_frame, r_up_next, r_down_next;
    logic        r_drop, r_menu, r_up_held, r_up_fresh, r_down_held, r_down_fresh;
    logic [7:0]  r_volume, r_bright, r_mute, r_jack;

    logic [31:0] n_frame_now, n_last_frame, n_up_next, n_down_next;
    logic        n_drop, n_menu, n_up_held, n_up_fresh, n_down_held, n_down_fresh;
    logic [7:0]  n_volume, n_bright, n_mute, n_jack;

    logic        vchg, bchg, sw;
    logic        menu_e, up_held_e, up_fresh_e, down_held_e, down_fresh_e;
    logic [31:0] up_next_e, down_next_e, up_diff, down_diff, gap_diff, press_next;
    logic        up_go, down_go, up_step, down_step, key_on;
    logic [7:0]  lvl0, lvl1, lvl2, top;

    always_comb begin
        up_held_e    = r_up_held   & ~r_drop;
        up_fresh_e   = r_up_fresh  & ~r_drop;
        down_held_e  = r_down_held & ~r_drop;
        down_fresh_e = r_down_fresh & ~r_drop;
        menu_e       = r_menu & ~r_drop;
        up_next_e    = r_drop ? 32'd0 : r_up_next;
        down_next_e  = r_drop ? 32'd0 : r_down_next;

        up_diff   = r_frame_now - up_next_e;
        down_diff = r_frame_now - down_next_e;
        up_go     = up_fresh_e   | (up_held_e   & ~up_diff[31]);
        down_go   = down_fresh_e | (down_held_e & ~down_diff[31]);

        lvl0      = menu_e ? r_bright : r_volume;
        top       = menu_e ? i_cfg.brightness_top : i_cfg.volume_top;
        up_step   = up_go & (lvl0 < top);
        lvl1      = up_step ? lvl0 + 8'd1 : lvl0;
        down_step = down_go & (lvl1 != 8'd0);
        lvl2      = down_step ? lvl1 - 8'd1 : lvl1;

        gap_diff   = i_item.time_ms - r_last_frame;
        press_next = r_frame_now + {16'd0, i_cfg.repeat_delay_ms};
        key_on     = i_item.event_value != 8'd0;

        n_frame_now  = r_frame_now;
        n_last_frame = r_last_frame;
        n_drop       = r_drop;
        n_menu       = r_menu;
        n_up_held    = r_up_held;
        n_up_fresh   = r_up_fresh;
        n_up_next    = r_up_next;
        n_down_held  = r_down_held;
        n_down_fresh = r_down_fresh;
        n_down_next  = r_down_next;
        n_volume     = r_volume;
        n_bright     = r_bright;
        n_mute       = r_mute;
        n_jack       = r_jack;
        vchg         = 1'b0;
        bchg         = 1'b0;
        sw           = 1'b0;

        unique case (i_item.operation)
            kal_pkg::OP_FRAME_START: begin
                n_frame_now = i_item.time_ms;
                n_drop      = gap_diff > {16'd0, i_cfg.sleep_gap_ms};
            end
            kal_pkg::OP_EVENT: begin
                if (!r_drop) begin
                    if (i_item.event_kind == kal_pkg::KIND_SWITCH) begin
                        if (i_item.event_code == kal_pkg::SW_JACK) begin
                            n_jack = i_item.event_value;
                            sw     = 1'b1;
                        end else if (i_item.event_code == kal_pkg::SW_MUTE) begin
                            n_mute = i_item.event_value;
                            sw     = 1'b1;
                        end
                    end else if (i_item.event_kind == kal_pkg::KIND_KEY &&
                                 i_item.event_value <= kal_pkg::KEY_VAL_MAX) begin
                        if (i_item.event_code == kal_pkg::KEY_MENU_A ||
                            i_item.event_code == kal_pkg::KEY_MENU_B ||
                            i_item.event_code == kal_pkg::KEY_MENU_C) begin
                            n_menu = key_on;
                        end else if (i_item.event_code == kal_pkg::KEY_PLUS) begin
                            n_up_held  = key_on;
                            n_up_fresh = key_on;
                            if (key_on) n_up_next = press_next;
                        end else if (i_item.event_code == kal_pkg::KEY_MINUS) begin
                            n_down_held  = key_on;
                            n_down_fresh = key_on;
                            if (key_on) n_down_next = press_next;
                        end
                    end
                end
            end
            kal_pkg::OP_FRAME_END: begin
                n_menu       = menu_e;
                n_up_held    = up_held_e;
                n_down_held  = down_held_e;
                n_up_fresh   = up_fresh_e & ~up_go;
                n_down_fresh = down_fresh_e & ~down_go;
                n_up_next    = (up_go && !up_fresh_e) ?
                               up_next_e + {16'd0, i_cfg.repeat_interval_ms} : up_next_e;
                n_down_next  = (down_go && !down_fresh_e) ?
                               down_next_e + {16'd0, i_cfg.repeat_interval_ms} : down_next_e;
                if (menu_e) begin
                    n_bright = lvl2;
                    bchg     = up_step | down_step;
                end else begin
                    n_volume = lvl2;
                    vchg     = up_step | down_step;
                end
                n_last_frame = r_frame_now;
                n_drop       = 1'b0;
            end
            kal_pkg::OP_LOAD: begin
                n_volume = (i_item.volume_load > i_cfg.volume_top) ?
                           i_cfg.volume_top : i_item.volume_load;
                n_bright = (i_item.brightness_load > i_cfg.brightness_top) ?
                           i_cfg.brightness_top : i_item.brightness_load;
            end
            default: ;
        endcase

        o_res.volume_level       = n_volume;
        o_res.brightness_level   = n_bright;
        o_res.mute_state         = n_mute;
        o_res.jack_state         = n_jack;
        o_res.volume_changed     = vchg;
        o_res.brightness_changed = bchg;
        o_res.switch_written     = sw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_now  <= '0;
            r_last_frame <= '0;
            r_drop       <= 1'b0;
            r_menu       <= 1'b0;
            r_up_held    <= 1'b0;
            r_up_fresh   <= 1'b0;
            r_up_next    <= '0;
            r_down_held  <= 1'b0;
            r_down_fresh <= 1'b0;
            r_down_next  <= '0;
            r_volume     <= '0;
            r_bright     <= '0;
            r_mute       <= '0;
            r_jack       <= '0;
        end else if (i_en) begin
            r_frame_now  <= n_frame_now;
            r_last_frame <= n_last_frame;
            r_drop       <= n_drop;
            r_menu       <= n_menu;
            r_up_held    <= n_up_held;
            r_up_fresh   <= n_up_fresh;
            r_up_next    <= n_up_next;
            r_down_held  <= n_down_held;
            r_down_fresh <= n_down_fresh;
            r_down_next  <= n_down_next;
            r_volume     <= n_volume;
            r_bright     <= n_bright;
            r_mute       <= n_mute;
            r_jack       <= n_jack;
        end
    end

endmodule

[rtl/key_autorepeat_level_control.sv]
// Volume and brightness level control with key auto-repeat. Frame starts,
// input events, frame ends and level loads enter on the slave stream; every
// beat produces exactly one result beat carrying the levels, switch states
// and change flags after that item. One beat is taken per clock cycle
// while the result side is not stalled. The accepting edge loads the input
// register; once the result side can take a beat, the result register is
// loaded from the combinational state update and presented. Both sides
// stall independently. Write the configuration registers only while idle.
module key_autorepeat_level_control (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [kal_pkg::CfgIdxW-1:0] i_cfg_addr,
    input  logic [15:0]                 i_cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // event_code[9:0], event_value[17:10], time_ms[49:18], volume_load[57:50],
    // brightness_load[65:58], zero pad[71:66]
    input  logic [71:0]                 s_axis_tdata,
    // operation[1:0], event_kind[3:2]
    input  logic [3:0]                  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // volume_level[7:0], brightness_level[15:8], mute_state[23:16], jack_state[31:24]
    output logic [31:0]                 m_axis_tdata,
    // volume_changed[0], brightness_changed[1], switch_written[2]
    output logic [2:0]                  m_axis_tuser
);

    kal_pkg::t_cfg    cfg;
    kal_pkg::t_item   r_item;
    kal_pkg::t_result res;
    kal_pkg::t_result r_res;
    logic             r_in_valid, r_out_valid, advance;

    kal_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    kal_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    assign advance       = r_in_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_in_valid | advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item.operation       <= kal_pkg::t_op'(s_axis_tuser[1:0]);
            r_item.event_kind      <= s_axis_tuser[3:2];
            r_item.event_code      <= s_axis_tdata[9:0];
            r_item.event_value     <= s_axis_tdata[17:10];
            r_item.time_ms         <= s_axis_tdata[49:18];
            r_item.volume_load     <= s_axis_tdata[57:50];
            r_item.brightness_load <= s_axis_tdata[65:58];
        end
        if (advance) begin
            r_res <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_res.jack_state, r_res.mute_state,
                            r_res.brightness_level, r_res.volume_level};
    assign m_axis_tuser  = {r_res.switch_written, r_res.brightness_changed,
                            r_res.volume_changed};

endmodule

[test/tb_key_autorepeat_level_control.sv]
`timescale 1ns / 100ps

module tb_key_autorepeat_level_control;

    localparam int CycleLimit = 200000;
    localparam logic [9:0] SwUnknown = 10'd3;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_wr_en;
    logic [kal_pkg::CfgIdxW-1:0]   i_cfg_addr;
    logic [15:0]                   i_cfg_wdata;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [71:0]                   s_axis_tdata;
    logic [3:0]                    s_axis_tuser;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [31:0]                   m_axis_tdata;
    logic [2:0]                    m_axis_tuser;

    key_autorepeat_level_control u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    logic [7:0]  top_volume   = kal_pkg::RST_VOLUME_TOP;
    logic [7:0]  top_bright   = kal_pkg::RST_BRIGHT_TOP;
    logic [15:0] rpt_delay    = kal_pkg::RST_REPEAT_DELAY;
    logic [15:0] rpt_interval = kal_pkg::RST_REPEAT_INTERVAL;
    logic [15:0] gap_limit    = kal_pkg::RST_SLEEP_GAP;

    logic [31:0] frame_ms      = '0;
    logic [31:0] prev_frame_ms = '0;
    logic        frame_dropped = 1'b0;
    logic        menu_down     = 1'b0;
    logic        plus_down     = 1'b0;
    logic        plus_new      = 1'b0;
    logic [31:0] plus_due_ms   = '0;
    logic        minus_down    = 1'b0;
    logic        minus_new     = 1'b0;
    logic [31:0] minus_due_ms  = '0;
    logic [7:0]  cur_volume    = '0;
    logic [7:0]  cur_bright    = '0;
    logic [7:0]  cur_mute      = '0;
    logic [7:0]  cur_jack      = '0;

    kal_pkg::t_result pending_levels[$];
    kal_pkg::t_result want;
    kal_pkg::t_result got;
    int      errors      = 0;
    int      items_sent  = 0;
    int      cycle_count = 0;
    logic    steady      = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("FAIL key_autorepeat_level_control");
            $finish;
        end
    end

    function automatic logic due_reached(input logic [31:0] at_ms, input logic [31:0] due_ms);
        logic [31:0] diff;
        diff = at_ms - due_ms;
        return !diff[31];
    endfunction

    function automatic logic step_level(input logic up);
        logic [7:0] lvl;
        logic [7:0] top;
        logic       changed;
        changed = 1'b0;
        lvl = menu_down ? cur_bright : cur_volume;
        top = menu_down ? top_bright : top_volume;
        if (up) begin
            if (lvl < top) begin
                lvl = lvl + 8'd1;
                changed = 1'b1;
            end
        end else if (lvl > 8'd0) begin
            lvl = lvl - 8'd1;
            changed = 1'b1;
        end
        if (menu_down) cur_bright = lvl;
        else cur_volume = lvl;
        return changed;
    endfunction

    function automatic kal_pkg::t_result predict_levels(input kal_pkg::t_item it);
        kal_pkg::t_result r;
        logic    vchg;
        logic    bchg;
        logic    sw;
        logic    on;
        logic    c;
        vchg = 1'b0;
        bchg = 1'b0;
        sw = 1'b0;
        case (it.operation)
            kal_pkg::OP_FRAME_START: begin
                frame_ms = it.time_ms;
                frame_dropped = (it.time_ms - prev_frame_ms) > {16'd0, gap_limit};
            end
            kal_pkg::OP_EVENT: begin
                if (!frame_dropped) begin
                    if (it.event_kind == kal_pkg::KIND_SWITCH) begin
                        if (it.event_code == kal_pkg::SW_JACK) begin
                            cur_jack = it.event_value;
                            sw = 1'b1;
                        end else if (it.event_code == kal_pkg::SW_MUTE) begin
                            cur_mute = it.event_value;
                            sw = 1'b1;
                        end
                    end else if (it.event_kind == kal_pkg::KIND_KEY &&
                                 it.event_value <= kal_pkg::KEY_VAL_MAX) begin
                        on = (it.event_value != 8'd0);
                        if (it.event_code == kal_pkg::KEY_MENU_A ||
                            it.event_code == kal_pkg::KEY_MENU_B ||
                            it.event_code == kal_pkg::KEY_MENU_C) begin
                            menu_down = on;
                        end else if (it.event_code == kal_pkg::KEY_PLUS) begin
                            plus_down = on;
                            plus_new = on;
                            if (on) plus_due_ms = frame_ms + {16'd0, rpt_delay};
                        end else if (it.event_code == kal_pkg::KEY_MINUS) begin
                            minus_down = on;
                            minus_new = on;
                            if (on) minus_due_ms = frame_ms + {16'd0, rpt_delay};
                        end
                    end
                end
            end
            kal_pkg::OP_FRAME_END: begin
                if (frame_dropped) begin
                    menu_down = 1'b0;
                    plus_down = 1'b0;
                    plus_new = 1'b0;
                    plus_due_ms = '0;
                    minus_down = 1'b0;
                    minus_new = 1'b0;
                    minus_due_ms = '0;
                end
                if (plus_new || (plus_down && due_reached(frame_ms, plus_due_ms))) begin
                    c = step_level(1'b1);
                    if (menu_down) bchg |= c;
                    else vchg |= c;
                    if (plus_new) plus_new = 1'b0;
                    else plus_due_ms = plus_due_ms + {16'd0, rpt_interval};
                end
                if (minus_new || (minus_down && due_reached(frame_ms, minus_due_ms))) begin
                    c = step_level(1'b0);
                    if (menu_down) bchg |= c;
                    else vchg |= c;
                    if (minus_new) minus_new = 1'b0;
                    else minus_due_ms = minus_due_ms + {16'd0, rpt_interval};
                end
                prev_frame_ms = frame_ms;
                frame_dropped = 1'b0;
            end
            kal_pkg::OP_LOAD: begin
                cur_volume = (it.volume_load > top_volume) ? top_volume : it.volume_load;
                cur_bright = (it.brightness_load > top_bright) ? top_bright : it.brightness_load;
            end
        endcase
        r.volume_level = cur_volume;
        r.brightness_level = cur_bright;
        r.mute_state = cur_mute;
        r.jack_state = cur_jack;
        r.volume_changed = vchg;
        r.brightness_changed = bchg;
        r.switch_written = sw;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.volume_level = m_axis_tdata[7:0];
            got.brightness_level = m_axis_tdata[15:8];
            got.mute_state = m_axis_tdata[23:16];
            got.jack_state = m_axis_tdata[31:24];
            got.volume_changed = m_axis_tuser[0];
            got.brightness_changed = m_axis_tuser[1];
            got.switch_written = m_axis_tuser[2];
            if (pending_levels.size() == 0) begin
                $display("%0t: result beat with nothing expected, expected none, actual %h",
                         $time, got);
                errors++;
            end else begin
                want = pending_levels.pop_front();
                check_field("volume_level", want.volume_level, got.volume_level);
                check_field("brightness_level", want.brightness_level, got.brightness_level);
                check_field("mute_state", want.mute_state, got.mute_state);
                check_field("jack_state", want.jack_state, got.jack_state);
                check_field("volume_changed", want.volume_changed, got.volume_changed);
                check_field("brightness_changed", want.brightness_changed,
                            got.brightness_changed);
                check_field("switch_written", want.switch_written, got.switch_written);
            end
        end
    end

    initial begin
        int stall;
        m_axis_tready = 1'b0;
        forever begin
            stall = steady ? 0 : $urandom_range(0, 6);
            repeat (stall) begin
                @(negedge i_clk);
                m_axis_tready = 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    function automatic kal_pkg::t_item rand_item();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return kal_pkg::t_item'(raw[$bits(kal_pkg::t_item)-1:0]);
    endfunction

    task automatic send_item(input kal_pkg::t_item it);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {6'd0, it.brightness_load, it.volume_load, it.time_ms,
                        it.event_value, it.event_code};
        s_axis_tuser = {it.event_kind, it.operation};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_levels.push_back(predict_levels(it));
        items_sent++;
    endtask

    task automatic send_start(input logic [31:0] at_ms);
        kal_pkg::t_item it;
        it = rand_item();
        it.operation = kal_pkg::OP_FRAME_START;
        it.time_ms = at_ms;
        send_item(it);
    endtask

    task automatic send_event(input logic [1:0] kind, input logic [9:0] code,
                              input logic [7:0] value);
        kal_pkg::t_item it;
        it = rand_item();
        it.operation = kal_pkg::OP_EVENT;
        it.event_kind = kind;
        it.event_code = code;
        it.event_value = value;
        send_item(it);
    endtask

    task automatic send_end();
        kal_pkg::t_item it;
        it = rand_item();
        it.operation = kal_pkg::OP_FRAME_END;
        send_item(it);
    endtask

    task automatic send_load(input logic [7:0] vol, input logic [7:0] bright);
        kal_pkg::t_item it;
        it = rand_item();
        it.operation = kal_pkg::OP_LOAD;
        it.volume_load = vol;
        it.brightness_load = bright;
        send_item(it);
    endtask

    // drop valid, then hold until every pending result beat is back
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_levels.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [kal_pkg::CfgIdxW-1:0] idx,
                             input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_addr = idx;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        i_cfg_addr = kal_pkg::CfgIdxW'($urandom);
        i_cfg_wdata = 16'($urandom);
        case (idx)
            kal_pkg::CFG_VOLUME_TOP:      top_volume = value[7:0];
            kal_pkg::CFG_BRIGHT_TOP:      top_bright = value[7:0];
            kal_pkg::CFG_REPEAT_DELAY:    rpt_delay = value;
            kal_pkg::CFG_REPEAT_INTERVAL: rpt_interval = value;
            kal_pkg::CFG_SLEEP_GAP:       gap_limit = value;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] vol_top, input logic [7:0] bright_top,
                              input logic [15:0] delay_ms, input logic [15:0] interval_ms,
                              input logic [15:0] gap_ms);
        write_reg(kal_pkg::CFG_VOLUME_TOP, {8'($urandom), vol_top});
        write_reg(kal_pkg::CFG_BRIGHT_TOP, {8'($urandom), bright_top});
        write_reg(kal_pkg::CFG_REPEAT_DELAY, delay_ms);
        write_reg(kal_pkg::CFG_REPEAT_INTERVAL, interval_ms);
        write_reg(kal_pkg::CFG_SLEEP_GAP, gap_ms);
    endtask

    task automatic test_switches();
        send_start(32'd1500);
        send_event(kal_pkg::KIND_SWITCH, kal_pkg::SW_MUTE, 8'hFF);
        send_end();
        send_start(32'd2000);
        send_event(kal_pkg::KIND_SWITCH, kal_pkg::SW_MUTE, 8'hFF);
        send_event(kal_pkg::KIND_SWITCH, kal_pkg::SW_JACK, 8'hA5);
        send_event(kal_pkg::KIND_SWITCH, SwUnknown, 8'h5A);
        send_end();
    endtask

    task automatic test_key_steps();
        send_load(8'd19, 8'd255);
        send_start(32'd2100);
        send_event(kal_pkg::KIND_KEY, kal_pkg::KEY_PLUS, 8'd1);
        send_end();
        send_start(32'd2400);
        send_end();
        send_start(32'd2450);
        send_event(kal_pkg::KIND_KEY, kal_pkg::KEY_MENU_B, 8'd1);
        send_event(kal_pkg::KIND_KEY, kal_pkg::KEY_MINUS, 8'd2);
        send_event(kal_pkg::KIND_KEY, kal_pkg::KEY_PLUS, 8'd3);
        send_end();
        send_end();
    endtask

    task automatic test_sleep_gap();
        send_start(32'hFFFF_FFF0);
        send_event(kal_pkg::KIND_KEY, kal_pkg::KEY_PLUS, 8'd1);
        send_end();
        send_start(32'h0000_0100);
        send_end();
    endtask

    task automatic test_config_writes();
        wait_idle();
        set_config(8'd1, kal_pkg::RST_BRIGHT_TOP, kal_pkg::RST_REPEAT_DELAY,
                   kal_pkg::RST_REPEAT_INTERVAL, kal_pkg::RST_SLEEP_GAP);
        write_reg(kal_pkg::CfgIdxW'(5), 16'hFFFF);
        write_reg(kal_pkg::CfgIdxW'(6), 16'hFFFF);
        write_reg(kal_pkg::CfgIdxW'(7), 16'hFFFF);
        send_start(32'h0000_0200);
        send_event(kal_pkg::KIND_KEY, kal_pkg::KEY_PLUS, 8'd1);
        send_event(kal_pkg::KIND_KEY, kal_pkg::KEY_MINUS, 8'd1);
        send_end();
    endtask

    task automatic test_random();
        int          phase;
        int          target;
        int          half;
        int          pick;
        int          n;
        logic        paused;
        logic [1:0]  kind;
        logic [9:0]  code;
        logic [7:0]  value;
        logic [31:0] at_ms;
        at_ms = prev_frame_ms;
        for (phase = 0; phase < 6; phase++) begin
            wait_idle();
            case (phase)
                0: set_config(kal_pkg::RST_VOLUME_TOP, kal_pkg::RST_BRIGHT_TOP,
                              kal_pkg::RST_REPEAT_DELAY, kal_pkg::RST_REPEAT_INTERVAL,
                              kal_pkg::RST_SLEEP_GAP);
                1: set_config(8'd255, 8'd255, 16'd0, 16'd1, 16'hFFFF);
                2: set_config(8'd1, 8'd1, 16'hFFFF, 16'hFFFF, 16'd0);
                4: set_config(8'd8, 8'd255, 16'd50, 16'd0, 16'd500);
                default: set_config(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                                    16'($urandom_range(0, 600)), 16'($urandom_range(1, 300)),
                                    16'($urandom_range(100, 3000)));
            endcase
            steady = (phase == 3);
            paused = 1'b0;
            target = items_sent + 92;
            half = items_sent + 46;
            while (items_sent < target) begin
                if (!paused && items_sent >= half) begin
                    wait_idle();
                    paused = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    send_item(rand_item());
                end else if (pick < 13) begin
                    send_load(8'($urandom), 8'($urandom));
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 15) at_ms = at_ms;
                    else if (pick < 85) at_ms = at_ms + $urandom_range(1, 160);
                    else if (pick < 95) at_ms = at_ms + $urandom_range(0, gap_limit + 100);
                    else at_ms = $urandom;
                    send_start(at_ms);
                    n = $urandom_range(0, 3);
                    repeat (n) begin
                        pick = $urandom_range(0, 99);
                        if (pick < 60) begin
                            kind = kal_pkg::KIND_KEY;
                            case ($urandom_range(0, 6))
                                0: code = kal_pkg::KEY_MENU_A;
                                1: code = kal_pkg::KEY_MENU_B;
                                2: code = kal_pkg::KEY_MENU_C;
                                3, 4: code = kal_pkg::KEY_PLUS;
                                default: code = kal_pkg::KEY_MINUS;
                            endcase
                            pick = $urandom_range(0, 99);
                            if (pick < 35) value = 8'd0;
                            else if (pick < 80) value = 8'd1;
                            else if (pick < 90) value = kal_pkg::KEY_VAL_MAX;
                            else value = 8'($urandom);
                        end else if (pick < 75) begin
                            kind = kal_pkg::KIND_SWITCH;
                            code = ($urandom_range(0, 4) == 0) ? 10'($urandom)
                                                               : 10'($urandom_range(0, 3));
                            value = 8'($urandom);
                        end else if (pick < 85) begin
                            kind = 2'($urandom_range(2, 3));
                            code = $urandom_range(0, 1) ? kal_pkg::KEY_PLUS : kal_pkg::KEY_MINUS;
                            value = 8'd1;
                        end else begin
                            kind = kal_pkg::KIND_KEY;
                            code = 10'($urandom);
                            value = 8'($urandom_range(0, 2));
                        end
                        send_event(kind, code, value);
                    end
                    if ($urandom_range(0, 19) != 0) send_end();
                end
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_switches();
        test_key_steps();
        test_sleep_gap();
        test_config_writes();
        test_random();

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (errors == 0 && pending_levels.size() == 0) begin
            $display("PASS key_autorepeat_level_control");
        end else begin
            $display("FAIL key_autorepeat_level_control");
        end
        $finish;
    end

endmodule
